// ===== hdl/sml_pkg.sv =====
// Shared types and constants for the segment motion limit block.
// Used by sml_front, sml_queue, sml_back and segment_motion_limits; no dependencies.
`default_nettype none
package sml_pkg;

    localparam int LIMIT_BITS = 21;
    localparam int DELTA_BITS = 24;
    localparam int AXES       = 3;
    localparam int ROOT_W     = DELTA_BITS + 1;
    localparam int SUM_W      = 2 * ROOT_W;
    localparam int PROD_W     = LIMIT_BITS + ROOT_W;
    localparam int LEN_W      = 24;
    localparam int FEED_W     = 21;
    localparam int REG_W      = 63;
    localparam int AXIS_W     = 2;
    localparam int STEP_W     = $clog2(ROOT_W + LIMIT_BITS + 1);
    localparam int QDEPTH     = 2;

    localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = {LIMIT_BITS{1'b1}};
    localparam logic [LEN_W-1:0]      LEN_MAX   = {LEN_W{1'b1}};

    typedef enum logic [1:0] {
        CFG_PATH_MODE = 2'd0,
        CFG_VEL       = 2'd1,
        CFG_ACC       = 2'd2,
        CFG_JERK      = 2'd3
    } cfg_index_t;

    localparam logic [1:0] PATH_CONTINUOUS = 2'd0;

    typedef struct packed {
        logic [1:0]       path_mode;
        logic [REG_W-1:0] vel;
        logic [REG_W-1:0] acc;
        logic [REG_W-1:0] jerk;
    } cfg_t;

    typedef struct packed {
        logic [AXES-1:0][DELTA_BITS-1:0] mag;
        logic [SUM_W-1:0]                sum;
        logic [FEED_W-1:0]               feed;
        logic                            seek;
        logic                            null_move;
    } move_t;

    typedef struct packed {
        logic [LEN_W-1:0]  move_length;
        logic [FEED_W-1:0] entry_velocity;
        logic [FEED_W-1:0] exit_velocity;
        logic [FEED_W-1:0] max_velocity;
        logic [FEED_W-1:0] max_accel;
        logic [FEED_W-1:0] max_jerk;
        logic              null_move;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/segment_motion_limits.sv =====
// Top level: configuration registers, front end, move queue and back end.
// Depends on sml_pkg, sml_front, sml_queue and sml_back.
//
//   channel | handshake              | payload
//   input   | in_valid / in_ready    | delta_x, delta_y, delta_z, feed_rate, seeking
//   result  | out_valid / out_ready  | move_length .. null_move
//   config  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// In the back end a move runs 25 square-root iterations, then per axis one multiply, one
// setup, 21 division steps for all three limits and one accumulate step, then the final
// state. A null move goes straight to the final state. The front end and a two-entry queue accept beats meanwhile.
// Reset clears configuration to zero; the config port is always ready.
// A stalled result holds the back end in its final state; the queue absorbs input.
`default_nettype none
module segment_motion_limits (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [sml_pkg::DELTA_BITS-1:0] delta_x,
    input  wire logic signed [sml_pkg::DELTA_BITS-1:0] delta_y,
    input  wire logic signed [sml_pkg::DELTA_BITS-1:0] delta_z,
    input  wire logic [sml_pkg::FEED_W-1:0]           feed_rate,
    input  wire logic                                 seeking,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [sml_pkg::LEN_W-1:0]                 move_length,
    output logic [sml_pkg::FEED_W-1:0]                entry_velocity,
    output logic [sml_pkg::FEED_W-1:0]                exit_velocity,
    output logic [sml_pkg::FEED_W-1:0]                max_velocity,
    output logic [sml_pkg::FEED_W-1:0]                max_accel,
    output logic [sml_pkg::FEED_W-1:0]                max_jerk,
    output logic                                      null_move,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [1:0]                           cfg_index,
    input  wire logic [sml_pkg::REG_W-1:0]            cfg_data
);

    sml_pkg::cfg_t    cfg_reg;
    sml_pkg::move_t   wr_data;
    sml_pkg::move_t   rd_data;
    sml_pkg::result_t result;
    logic             wr_valid;
    logic             wr_ready;
    logic             rd_valid;
    logic             rd_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (sml_pkg::cfg_index_t'(cfg_index))
                sml_pkg::CFG_PATH_MODE: cfg_reg.path_mode <= cfg_data[1:0];
                sml_pkg::CFG_VEL:       cfg_reg.vel       <= cfg_data;
                sml_pkg::CFG_ACC:       cfg_reg.acc       <= cfg_data;
                sml_pkg::CFG_JERK:      cfg_reg.jerk      <= cfg_data;
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    sml_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .delta_x  (delta_x),
        .delta_y  (delta_y),
        .delta_z  (delta_z),
        .feed_rate(feed_rate),
        .seeking  (seeking),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data)
    );

    sml_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_valid(wr_valid),
        .wr_ready(wr_ready),
        .wr_data (wr_data),
        .rd_valid(rd_valid),
        .rd_ready(rd_ready),
        .rd_data (rd_data)
    );

    sml_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result   (result)
    );

    assign move_length    = result.move_length;
    assign entry_velocity = result.entry_velocity;
    assign exit_velocity  = result.exit_velocity;
    assign max_velocity   = result.max_velocity;
    assign max_accel      = result.max_accel;
    assign max_jerk       = result.max_jerk;
    assign null_move      = result.null_move;

endmodule
`default_nettype wire

// ===== hdl/sml_front.sv =====
// Front end: takes input beats, forms axis magnitudes and the squared length.
// Depends on sml_pkg.
`default_nettype none
module sml_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [sml_pkg::DELTA_BITS-1:0] delta_x,
    input  wire logic signed [sml_pkg::DELTA_BITS-1:0] delta_y,
    input  wire logic signed [sml_pkg::DELTA_BITS-1:0] delta_z,
    input  wire logic [sml_pkg::FEED_W-1:0]           feed_rate,
    input  wire logic                                 seeking,
    output logic                                      wr_valid,
    input  wire logic                                 wr_ready,
    output sml_pkg::move_t                            wr_data
);

    logic                                           st_valid_reg;
    logic [sml_pkg::AXES-1:0][sml_pkg::DELTA_BITS-1:0] mag_reg;
    logic [sml_pkg::FEED_W-1:0]                     feed_reg;
    logic                                           seek_reg;
    logic [sml_pkg::AXES-1:0][sml_pkg::DELTA_BITS-1:0] mag_next;
    logic [sml_pkg::AXES-1:0][sml_pkg::DELTA_BITS-1:0] raw;
    logic [sml_pkg::SUM_W-1:0]                      sum;

    assign in_ready = !st_valid_reg || wr_ready;
    assign raw[0] = delta_x;
    assign raw[1] = delta_y;
    assign raw[2] = delta_z;

    always_comb
    begin
        for (int a = 0; a < sml_pkg::AXES; a++)
        begin
            mag_next[a] = raw[a][sml_pkg::DELTA_BITS-1] ? (~raw[a] + 1'b1) : raw[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            st_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mag_reg  <= mag_next;
            feed_reg <= feed_rate;
            seek_reg <= seeking;
        end
    end

    always_comb
    begin
        sum = '0;
        for (int a = 0; a < sml_pkg::AXES; a++)
        begin
            sum = sum + sml_pkg::SUM_W'(mag_reg[a] * mag_reg[a]);
        end
    end

    assign wr_valid          = st_valid_reg;
    assign wr_data.mag       = mag_reg;
    assign wr_data.sum       = sum;
    assign wr_data.feed      = feed_reg;
    assign wr_data.seek      = seek_reg;
    assign wr_data.null_move = (mag_reg == '0);

endmodule
`default_nettype wire

// ===== hdl/sml_queue.sv =====
// Two-entry queue of classified moves between front and back end.
// Depends on sml_pkg.
`default_nettype none
module sml_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire sml_pkg::move_t wr_data,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output sml_pkg::move_t      rd_data
);

    sml_pkg::move_t mem [sml_pkg::QDEPTH];
    logic           wp_reg;
    logic           rp_reg;
    logic [1:0]     cnt_reg;
    logic           push;
    logic           pop;

    assign wr_ready = (cnt_reg != 2'(sml_pkg::QDEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(sml_pkg::QDEPTH))
        else $error("queue count beyond depth");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'(sml_pkg::QDEPTH)) |-> (wp_reg == rp_reg))
        else $error("queue pointers disagree with count");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count missed a push");

endmodule
`default_nettype wire

// ===== hdl/sml_back.sv =====
// Back end: square root, per-axis limit projection by long division, minima, result.
// Depends on sml_pkg.
`default_nettype none
module sml_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sml_pkg::cfg_t  cfg,
    input  wire logic           rd_valid,
    output logic                rd_ready,
    input  wire sml_pkg::move_t rd_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output sml_pkg::result_t    result
);

    typedef enum logic [2:0] {S_IDLE, S_SQRT, S_MUL, S_PRE, S_DIV, S_ACC, S_FIN} state_t;

    localparam int RW = sml_pkg::ROOT_W + 1;
    localparam int DB = sml_pkg::DELTA_BITS;
    localparam int LB = sml_pkg::LIMIT_BITS;

    state_t                          state_reg;
    sml_pkg::move_t                  cur_reg;
    logic [RW-1:0]                   rem_reg;
    logic [sml_pkg::ROOT_W-1:0]      root_reg;
    logic [sml_pkg::SUM_W-1:0]       rad_reg;
    logic [sml_pkg::STEP_W-1:0]      step_reg;
    logic [sml_pkg::AXIS_W-1:0]      axis_reg;
    logic [2:0][sml_pkg::PROD_W-1:0] prod_reg;
    logic [2:0]                      sat_reg;
    logic [2:0][DB-1:0]              qrem_reg;
    logic [2:0][LB-1:0]              quo_reg;
    logic [sml_pkg::FEED_W-1:0]      vmax_reg;
    logic [LB-1:0]                   amax_reg;
    logic [LB-1:0]                   jmax_reg;
    logic                            out_valid_reg;
    sml_pkg::result_t                result_reg;

    logic [RW+1:0]                   cand;
    logic [RW+1:0]                   trial;
    logic [2:0][LB-1:0]              lim;
    logic [DB-1:0]                   mag;
    logic [2:0][LB-1:0]              proj;
    logic [sml_pkg::FEED_W-1:0]      entry;
    logic [sml_pkg::FEED_W-1:0]      exitv;
    logic [sml_pkg::ROOT_W+sml_pkg::LEN_W-1:0] len_ext;

    assign rd_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    assign cand    = {rem_reg, rad_reg[sml_pkg::SUM_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign mag     = cur_reg.mag[axis_reg];
    assign lim[0]  = cfg.vel[axis_reg*LB +: LB];
    assign lim[1]  = cfg.acc[axis_reg*LB +: LB];
    assign lim[2]  = cfg.jerk[axis_reg*LB +: LB];
    assign len_ext = (sml_pkg::ROOT_W + sml_pkg::LEN_W)'(root_reg);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            proj[k] = sat_reg[k] ? sml_pkg::LIMIT_MAX : quo_reg[k];
        end
        entry = (cur_reg.null_move || cfg.path_mode == sml_pkg::PATH_CONTINUOUS)
                ? cur_reg.feed : '0;
        if (cfg.path_mode != sml_pkg::PATH_CONTINUOUS)
        begin
            entry = '0;
        end
        exitv = (cur_reg.seek && !cur_reg.null_move) ? '0 : entry;
        if (vmax_reg < entry)
        begin
            entry = vmax_reg;
        end
        if (vmax_reg < exitv)
        begin
            exitv = vmax_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            axis_reg      <= '0;
        end
        else
        begin
            // The final state sets valid itself whenever it hands over a result.
            if (out_valid_reg && out_ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (rd_valid)
                    begin
                        cur_reg  <= rd_data;
                        vmax_reg <= rd_data.feed;
                        amax_reg <= sml_pkg::LIMIT_MAX;
                        jmax_reg <= sml_pkg::LIMIT_MAX;
                        rem_reg  <= '0;
                        root_reg <= '0;
                        rad_reg  <= rd_data.sum;
                        step_reg <= '0;
                        axis_reg <= '0;
                        state_reg <= rd_data.null_move ? S_FIN : S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (cand >= trial)
                    begin
                        rem_reg  <= RW'(cand - trial);
                        root_reg <= {root_reg[sml_pkg::ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= cand[RW-1:0];
                        root_reg <= {root_reg[sml_pkg::ROOT_W-2:0], 1'b0};
                    end
                    rad_reg <= rad_reg << 2;
                    if (step_reg == sml_pkg::STEP_W'(sml_pkg::ROOT_W - 1))
                    begin
                        state_reg <= S_MUL;
                    end
                    step_reg <= step_reg + 1'b1;
                end
                S_MUL:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        prod_reg[k] <= sml_pkg::PROD_W'(lim[k] * root_reg);
                    end
                    state_reg <= S_PRE;
                end
                S_PRE:
                begin
                    // The quotient saturates exactly when the high part reaches the divisor.
                    for (int k = 0; k < 3; k++)
                    begin
                        sat_reg[k]  <= ((sml_pkg::ROOT_W + DB)'(prod_reg[k][sml_pkg::PROD_W-1:LB])
                                        >= (sml_pkg::ROOT_W + DB)'(mag));
                        qrem_reg[k] <= DB'(prod_reg[k][sml_pkg::PROD_W-1:LB]);
                        quo_reg[k]  <= '0;
                    end
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if ({qrem_reg[k], prod_reg[k][LB-1]} >= {1'b0, mag})
                        begin
                            qrem_reg[k] <= DB'({qrem_reg[k], prod_reg[k][LB-1]} - {1'b0, mag});
                            quo_reg[k]  <= {quo_reg[k][LB-2:0], 1'b1};
                        end
                        else
                        begin
                            qrem_reg[k] <= {qrem_reg[k][DB-2:0], prod_reg[k][LB-1]};
                            quo_reg[k]  <= {quo_reg[k][LB-2:0], 1'b0};
                        end
                        prod_reg[k] <= prod_reg[k] << 1;
                    end
                    if (step_reg == sml_pkg::STEP_W'(LB - 1))
                    begin
                        state_reg <= S_ACC;
                    end
                    step_reg <= step_reg + 1'b1;
                end
                S_ACC:
                begin
                    if (mag != '0)
                    begin
                        if (lim[0] != '0 && sml_pkg::FEED_W'(proj[0]) < vmax_reg)
                        begin
                            vmax_reg <= sml_pkg::FEED_W'(proj[0]);
                        end
                        if (lim[1] != '0 && proj[1] < amax_reg)
                        begin
                            amax_reg <= proj[1];
                        end
                        if (lim[2] != '0 && proj[2] < jmax_reg)
                        begin
                            jmax_reg <= proj[2];
                        end
                    end
                    if (axis_reg == sml_pkg::AXIS_W'(sml_pkg::AXES - 1))
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        result_reg.move_length <=
                            (len_ext > (sml_pkg::ROOT_W + sml_pkg::LEN_W)'(sml_pkg::LEN_MAX))
                            ? sml_pkg::LEN_MAX : len_ext[sml_pkg::LEN_W-1:0];
                        result_reg.entry_velocity <= entry;
                        result_reg.exit_velocity  <= exitv;
                        result_reg.max_velocity   <= vmax_reg;
                        result_reg.max_accel      <= sml_pkg::FEED_W'(amax_reg);
                        result_reg.max_jerk       <= sml_pkg::FEED_W'(jmax_reg);
                        result_reg.null_move      <= cur_reg.null_move;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_sqrt_steps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQRT |-> step_reg < sml_pkg::STEP_W'(sml_pkg::ROOT_W))
        else $error("square root ran past its iterations");
    a_null_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.null_move) |-> result_reg.move_length == '0)
        else $error("null move with nonzero length");
    a_entry_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.entry_velocity <= result_reg.max_velocity
                           && result_reg.exit_velocity <= result_reg.max_velocity))
        else $error("velocity not clamped");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for segment_motion_limits: directed table, then random moves.
// Depends on sml_pkg and the segment_motion_limits RTL; predicts results internally.
`timescale 1ns / 1ps
module tb_top;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [sml_pkg::DELTA_BITS-1:0] delta_x = '0, delta_y = '0, delta_z = '0;
    logic [sml_pkg::FEED_W-1:0] feed_rate = '0;
    logic seeking = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [sml_pkg::LEN_W-1:0] move_length;
    logic [sml_pkg::FEED_W-1:0] entry_velocity, exit_velocity, max_velocity;
    logic [sml_pkg::FEED_W-1:0] max_accel, max_jerk;
    logic null_move;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [sml_pkg::REG_W-1:0] cfg_data = '0;

    always #4 clk = ~clk;

    segment_motion_limits dut (.*);

    typedef struct {
        logic signed [sml_pkg::DELTA_BITS-1:0] dx, dy, dz;
        logic [sml_pkg::FEED_W-1:0] feed;
        logic seek;
        bit typed;
        sml_pkg::result_t res;
    } move_row_t;

    // Shadow copy of the configuration registers.
    logic [1:0] sh_mode;
    logic [sml_pkg::REG_W-1:0] sh_vel, sh_acc, sh_jerk;

    sml_pkg::result_t pending_results[$];
    int errors = 0;
    int moves_sent = 0;
    int results_seen = 0;
    int null_seen = 0;
    int idle_cycles = 0;
    bit stall_free = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
            begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic sml_pkg::result_t predict_limits(
            input logic signed [sml_pkg::DELTA_BITS-1:0] dx,
            input logic signed [sml_pkg::DELTA_BITS-1:0] dy,
            input logic signed [sml_pkg::DELTA_BITS-1:0] dz,
            input logic [sml_pkg::FEED_W-1:0] feed, input logic seek);
        logic [63:0] mag[3];
        logic [63:0] sum, len, vmax, amax, jmax, entry, exitv, lim, p;
        logic [sml_pkg::REG_W-1:0] regs[3];
        sml_pkg::result_t r;
        mag[0] = dx < 0 ? 64'(-65'(dx)) : 64'(dx);
        mag[1] = dy < 0 ? 64'(-65'(dy)) : 64'(dy);
        mag[2] = dz < 0 ? 64'(-65'(dz)) : 64'(dz);
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        regs[0] = sh_vel;
        regs[1] = sh_acc;
        regs[2] = sh_jerk;
        vmax = 64'(feed);
        amax = 64'(sml_pkg::LIMIT_MAX);
        jmax = 64'(sml_pkg::LIMIT_MAX);
        entry = (sh_mode != sml_pkg::PATH_CONTINUOUS) ? 64'd0 : 64'(feed);
        exitv = entry;
        if (sum == 0)
        begin
            r.move_length = '0;
            r.entry_velocity = entry[sml_pkg::FEED_W-1:0];
            r.exit_velocity = exitv[sml_pkg::FEED_W-1:0];
            r.max_velocity = vmax[sml_pkg::FEED_W-1:0];
            r.max_accel = amax[sml_pkg::FEED_W-1:0];
            r.max_jerk = jmax[sml_pkg::FEED_W-1:0];
            r.null_move = 1'b1;
            return r;
        end
        len = int_sqrt(sum);
        for (int a = 0; a < 3; a++)
        begin
            if (mag[a] == 0) continue;
            for (int k = 0; k < 3; k++)
            begin
                lim = (64'(regs[k]) >> (a * sml_pkg::LIMIT_BITS)) & 64'(sml_pkg::LIMIT_MAX);
                if (lim == 0) continue;
                p = (lim * len) / mag[a];
                if (p > 64'(sml_pkg::LIMIT_MAX)) p = 64'(sml_pkg::LIMIT_MAX);
                if (k == 0 && p < vmax) vmax = p;
                if (k == 1 && p < amax) amax = p;
                if (k == 2 && p < jmax) jmax = p;
            end
        end
        if (seek) exitv = 0;
        if (vmax < entry) entry = vmax;
        if (vmax < exitv) exitv = vmax;
        r.move_length = len > 64'(sml_pkg::LEN_MAX) ? sml_pkg::LEN_MAX
                                                    : len[sml_pkg::LEN_W-1:0];
        r.entry_velocity = entry[sml_pkg::FEED_W-1:0];
        r.exit_velocity = exitv[sml_pkg::FEED_W-1:0];
        r.max_velocity = vmax[sml_pkg::FEED_W-1:0];
        r.max_accel = amax[sml_pkg::FEED_W-1:0];
        r.max_jerk = jmax[sml_pkg::FEED_W-1:0];
        r.null_move = 1'b0;
        return r;
    endfunction

    // Result side: random stalls, compare every accepted beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= stall_free ? 1'b1 : ($urandom_range(99) >= 10);
            if (out_valid && out_ready)
            begin
                sml_pkg::result_t want;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result beat with no move pending", 1, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (null_move) null_seen++;
                    if (move_length !== want.move_length)
                        report_mismatch("move_length", move_length, want.move_length);
                    if (entry_velocity !== want.entry_velocity)
                        report_mismatch("entry_velocity", entry_velocity, want.entry_velocity);
                    if (exit_velocity !== want.exit_velocity)
                        report_mismatch("exit_velocity", exit_velocity, want.exit_velocity);
                    if (max_velocity !== want.max_velocity)
                        report_mismatch("max_velocity", max_velocity, want.max_velocity);
                    if (max_accel !== want.max_accel)
                        report_mismatch("max_accel", max_accel, want.max_accel);
                    if (max_jerk !== want.max_jerk)
                        report_mismatch("max_jerk", max_jerk, want.max_jerk);
                    if (null_move !== want.null_move)
                        report_mismatch("null_move", null_move, want.null_move);
                end
            end
        end
    end

    // Watchdog over cycles with no accepted beat on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Timeout: no beat accepted for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input sml_pkg::cfg_index_t idx,
                             input logic [sml_pkg::REG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            sml_pkg::CFG_PATH_MODE: sh_mode = val[1:0];
            sml_pkg::CFG_VEL: sh_vel = val;
            sml_pkg::CFG_ACC: sh_acc = val;
            default: sh_jerk = val;
        endcase
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // Sends one move; a typed expectation replaces the prediction when given.
    // Valid is left high at the end of a move so that beats can follow back to back.
    task automatic send_move(input move_row_t m);
        sml_pkg::result_t want;
        while (!stall_free && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        delta_x <= m.dx;
        delta_y <= m.dy;
        delta_z <= m.dz;
        feed_rate <= m.feed;
        seeking <= m.seek;
        want = m.typed ? m.res : predict_limits(m.dx, m.dy, m.dz, m.feed, m.seek);
        pending_results = {pending_results, want};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        moves_sent++;
    endtask

    function automatic logic signed [sml_pkg::DELTA_BITS-1:0] rand_delta(input int sz);
        case (sz)
            0: return '0;
            1: return sml_pkg::DELTA_BITS'($urandom_range(0, 600) - 300);
            2: return sml_pkg::DELTA_BITS'($urandom);
            default: return $urandom_range(1) ? {1'b1, {(sml_pkg::DELTA_BITS-1){1'b0}}}
                                               : {1'b0, {(sml_pkg::DELTA_BITS-1){1'b1}}};
        endcase
    endfunction

    function automatic logic [sml_pkg::REG_W-1:0] rand_limits();
        logic [sml_pkg::REG_W-1:0] v;
        v = sml_pkg::REG_W'({$urandom, $urandom});
        for (int a = 0; a < 3; a++)
        begin
            case ($urandom_range(3))
                0: v[a*sml_pkg::LIMIT_BITS +: sml_pkg::LIMIT_BITS] = '0;
                1: v[a*sml_pkg::LIMIT_BITS +: sml_pkg::LIMIT_BITS] =
                       sml_pkg::LIMIT_BITS'($urandom_range(1, 2000));
                default: ;
            endcase
        end
        return v;
    endfunction

    move_row_t directed[$];
    move_row_t m;
    localparam logic signed [sml_pkg::DELTA_BITS-1:0] DMAX =
        {1'b0, {(sml_pkg::DELTA_BITS-1){1'b1}}};
    localparam logic signed [sml_pkg::DELTA_BITS-1:0] DMIN =
        {1'b1, {(sml_pkg::DELTA_BITS-1){1'b0}}};
    localparam logic [sml_pkg::FEED_W-1:0] FMAX = {sml_pkg::FEED_W{1'b1}};
    localparam logic [sml_pkg::FEED_W-1:0] LMAX = sml_pkg::LIMIT_MAX;

    initial
    begin
        sh_mode = '0;
        sh_vel = '0;
        sh_acc = '0;
        sh_jerk = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: null, plain, seek and extreme moves; the first four have typed expectations.
        directed = '{
            '{0, 0, 0, 1000, 1'b1, 1, '{0, 1000, 1000, 1000, LMAX, LMAX, 1'b1}},
            '{3, 4, 0, 500, 1'b0, 1, '{5, 500, 500, 500, LMAX, LMAX, 1'b0}},
            '{3, 4, 0, 500, 1'b1, 1, '{5, 500, 0, 500, LMAX, LMAX, 1'b0}},
            '{DMIN, 0, 0, FMAX, 1'b0, 1, '{24'h800000, FMAX, FMAX, FMAX, LMAX,
                LMAX, 1'b0}},
            '{DMAX, DMIN, DMAX, 0, 1'b0, 0, '0},
            '{-1, 1, -1, FMAX, 1'b1, 0, '0}
        };
        foreach (directed[i]) send_move(directed[i]);
        drain_results();

        // Limits at their extremes and each of the four path mode values.
        for (int mode = 0; mode < 4; mode++)
        begin
            write_reg(sml_pkg::CFG_PATH_MODE, sml_pkg::REG_W'(mode));
            write_reg(sml_pkg::CFG_VEL,
                      mode[0] ? {sml_pkg::REG_W{1'b1}} : {21'd1, 21'd100, 21'd1000});
            write_reg(sml_pkg::CFG_ACC,
                      mode[1] ? {sml_pkg::REG_W{1'b1}} : {21'd7, 21'd0, 21'd50});
            write_reg(sml_pkg::CFG_JERK, {21'd3, 21'd0, 21'd0});
            directed = '{
                '{0, 0, 0, 777, 1'b0, 0, '0},
                '{DMAX, DMAX, DMAX, FMAX, 1'b1, 0, '0},
                '{1, 0, 0, FMAX, 1'b0, 0, '0},
                '{0, -5, 12, 90, 1'b1, 0, '0}
            };
            foreach (directed[i]) send_move(directed[i]);
            drain_results();
        end

        // Random phases with a fresh configuration each; one phase runs without idling.
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(sml_pkg::CFG_PATH_MODE, sml_pkg::REG_W'($urandom_range(3))
                      | (sml_pkg::REG_W'($urandom) << 2));
            write_reg(sml_pkg::CFG_VEL, rand_limits());
            write_reg(sml_pkg::CFG_ACC, rand_limits());
            write_reg(sml_pkg::CFG_JERK, rand_limits());
            stall_free = (ph == 4);
            for (int n = 0; n < 100; n++)
            begin
                m.dx = rand_delta($urandom_range(9) < 2 ? 0 : $urandom_range(1, 3));
                m.dy = rand_delta($urandom_range(9) < 3 ? 0 : $urandom_range(1, 3));
                m.dz = rand_delta($urandom_range(9) < 3 ? 0 : $urandom_range(1, 3));
                if ($urandom_range(19) == 0)
                begin
                    m.dx = 0;
                    m.dy = 0;
                    m.dz = 0;
                end
                m.feed = $urandom_range(3) == 0 ? sml_pkg::FEED_W'($urandom_range(2000))
                                                : sml_pkg::FEED_W'($urandom);
                m.seek = $urandom_range(1);
                m.typed = 0;
                send_move(m);
            end
            drain_results();
            stall_free = 1'b0;
        end

        $display("Sent %0d moves, checked %0d results (%0d null moves).",
                 moves_sent, results_seen, null_seen);
        $display("Covered all path modes, limit extremes, saturation and random configurations.");
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Leftover expectations: %0d, mismatches: %0d",
                     pending_results.size(), errors);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
